// File: rtl/dpts_pkg.sv
// shared types and constants for the dominant pole two-means selector
// depends on nothing
package dpts_pkg;

  localparam int MaxPoles = 32;
  localparam int Iterations = 10;
  localparam int IdxW = 5;
  localparam int CntW = 6;
  localparam int TauW = 48;
  localparam int ItW = 4;
  localparam logic [TauW-1:0] TauMax = {TauW{1'b1}};

  typedef struct packed {
    logic signed [31:0] pole_real;
    logic               last_pole;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  pole_index;
    logic        index_valid;
    logic        last_result;
    logic [5:0]  dom_count;
    logic [47:0] cluster_time_constant;
    logic [47:0] fastest_time_constant;
    logic [47:0] tau_ratio;
    logic        degenerate;
    logic        too_many;
  } out_item_t;

  // datapath commands
  typedef struct packed {
    logic div_start;   // start divider with operands chosen by div_op
    logic store_tau;   // write divider result to store at pole_count
    logic store_inf;   // write an infinite entry
    logic seed;        // load centroids from range
    logic clr_acc;     // clear the sums
    logic acc;         // accumulate read data
    logic mean_sel;    // 0: cluster 1, 1: cluster 2 for the mean division
    logic load_c;      // load centroid from divider
    logic emit_idx;    // test read entry and emit if dominant
    logic emit_sum;    // emit summary
    logic clear_set;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic degen;
    logic n1_zero;
    logic n2_zero;
    logic ratio_sat;
  } stat_t;

  typedef enum logic [1:0] {
    DivRecip = 2'd0,
    DivMean  = 2'd1,
    DivRatio = 2'd2
  } div_op_e;

endpackage

// File: rtl/dominant_pole_two_means_select.sv
// top level of the dominant pole two-means selector
// depends on dpts_pkg, dpts_ctrl, dpts_datapath
//
// usage: drive item and raise start; the pole is taken at an edge where
// start is high and busy low. each pole's time constant is a 64 step
// shift-subtract division, and busy stays high until it is stored; a zero
// real part stores an infinite entry without a division, and a pole
// beyond capacity not marked last leaves busy low, so one is taken per cycle.
// after the pole marked last_pole the block clusters: each of the ten
// rounds reads every stored entry and runs up to two divisions for the
// means (none for an empty cluster), then a scan of every entry emits
// dominant indices, and a division gives the ratio before the summary.
// a range with no spread goes from the check straight to the summary.
// results appear for one cycle each with strobe high; the receiver
// cannot stall them, and each one is a transfer on that edge.
// reset clears the pole count, overflow flag, range and centroids; the
// time constant store is not cleared and needs no clearing pass.
module dominant_pole_two_means_select (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  dpts_pkg::in_item_t  item,
  output logic                busy,
  output logic                strobe,
  output dpts_pkg::out_item_t result
);
  import dpts_pkg::*;

  cmd_t      cmd;
  stat_t     stat;
  div_op_e   div_op;
  logic [31:0] mag;
  logic [4:0]  addr, out_idx;
  logic [5:0]  nd_count;
  logic        overflow, is_dom;

  dpts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .in_item(item), .stat(stat),
    .is_dom(is_dom), .busy(busy), .cmd(cmd), .div_op(div_op), .mag(mag),
    .addr(addr), .out_idx(out_idx), .nd_count(nd_count), .overflow(overflow),
    .strobe(strobe)
  );

  dpts_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .div_op(div_op), .mag(mag),
    .addr(addr), .out_idx(out_idx), .nd_count(nd_count), .overflow(overflow),
    .stat(stat), .is_dom(is_dom), .result(result)
  );

  // a summary is never followed by another result without a new pole
  a_sum_then_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_result |=> !strobe)
    else $error("result after summary");

  // index items and summary items are exclusive
  a_kind: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.index_valid != result.last_result))
    else $error("bad result kind");

  // degenerate summaries select nothing
  a_degen: assert property (@(posedge clk) disable iff (rst)
    strobe && result.degenerate |-> result.dom_count == 6'd0)
    else $error("degenerate with selection");
endmodule

// File: rtl/dpts_ram.sv
// generic single port ram with registered read
// depends on nothing
module dpts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: rtl/dpts_div.sv
// 64 by 48 bit restoring divider, one quotient bit per cycle
// depends on dpts_pkg
module dpts_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [47:0] den,
  output logic        done,
  output logic [63:0] quo
);
  import dpts_pkg::*;
  logic [48:0] rem;
  logic [63:0] q;
  logic [47:0] d;
  logic [6:0]  cnt;
  logic        busy;
  logic [48:0] trial;
  logic [48:0] shifted;

  assign shifted = {rem[47:0], q[63]};
  assign trial   = shifted - {1'b0, d};
  assign quo     = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        rem  <= '0;
        q    <= num;
        d    <= den;
      end else if (busy) begin
        if (!trial[48]) begin
          rem <= trial;
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: rtl/dpts_datapath.sv
// store, range tracking, cluster sums and divider of the selector
// depends on dpts_pkg, dpts_ram, dpts_div
module dpts_datapath (
  input  logic                clk,
  input  logic                rst,
  input  dpts_pkg::cmd_t      cmd,
  input  dpts_pkg::div_op_e   div_op,
  input  logic [31:0]         mag,
  input  logic [4:0]          addr,
  input  logic [4:0]          out_idx,
  input  logic [5:0]          nd_count,
  input  logic                overflow,
  output dpts_pkg::stat_t     stat,
  output logic                is_dom,
  output dpts_pkg::out_item_t result
);
  import dpts_pkg::*;

  logic [TauW-1:0] range_min, range_max, c1, c2;
  logic [TauW+5:0] s1, s2;
  logic [CntW-1:0] n1, n2;
  logic [TauW:0]   rdata;
  logic            we;
  logic [TauW:0]   wdata;
  logic [63:0]     num;
  logic [47:0]     den;
  logic            div_done;
  logic [63:0]     quo;
  logic [TauW-1:0] tau_new, span, t;
  logic            fin;
  logic [TauW-1:0] d1, d2;
  logic [TauW:0]   csum;
  logic [TauW-1:0] hi;
  out_item_t       result_next;

  assign tau_new = quo[TauW-1:0];
  assign we      = cmd.store_tau | cmd.store_inf;
  assign wdata   = cmd.store_tau ? {1'b1, tau_new} : '0;

  dpts_ram #(.Width(TauW + 1), .Depth(MaxPoles)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_comb begin
    num = '0;
    den = '0;
    case (div_op)
      DivRecip: begin
        num = 64'h1_0000_0000;
        den = {16'd0, mag};
      end
      DivMean: begin
        num = cmd.mean_sel ? {10'd0, s2} : {10'd0, s1};
        den = cmd.mean_sel ? {42'd0, n2} : {42'd0, n1};
      end
      DivRatio: begin
        num = {hi, 16'd0};
        den = range_min;
      end
      default: ;
    endcase
  end

  dpts_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(num), .den(den),
    .done(div_done), .quo(quo)
  );

  assign span = range_max - range_min;
  assign t    = rdata[TauW-1:0];
  assign fin  = rdata[TauW];
  assign d1   = (t > c1) ? t - c1 : c1 - t;
  assign d2   = (t > c2) ? t - c2 : c2 - t;
  assign csum = {1'b0, c1} + {1'b0, c2};
  assign hi   = (c1 > c2) ? c1 : c2;
  assign is_dom = fin && ({t, 1'b0} > csum);

  assign stat.div_done  = div_done;
  assign stat.degen     = range_max <= range_min;
  assign stat.n1_zero   = n1 == '0;
  assign stat.n2_zero   = n2 == '0;
  assign stat.ratio_sat = hi[TauW-1:32] != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min <= TauMax;
      range_max <= '0;
      c1 <= '0;
      c2 <= '0;
      s1 <= '0;
      s2 <= '0;
      n1 <= '0;
      n2 <= '0;
    end else begin
      if (cmd.store_tau) begin
        if (tau_new < range_min) range_min <= tau_new;
        if (tau_new > range_max) range_max <= tau_new;
      end
      if (cmd.seed) begin
        c1 <= range_min + (span >> 2);
        c2 <= range_min + TauW'(({2'b0, span} * 50'd3) >> 2);
      end
      if (cmd.clr_acc) begin
        s1 <= '0; s2 <= '0; n1 <= '0; n2 <= '0;
      end else if (cmd.acc && fin) begin
        if (d1 < d2) begin
          s1 <= s1 + {6'd0, t};
          n1 <= n1 + 6'd1;
        end else begin
          s2 <= s2 + {6'd0, t};
          n2 <= n2 + 6'd1;
        end
      end
      if (cmd.load_c) begin
        if (cmd.mean_sel) c2 <= tau_new;
        else              c1 <= tau_new;
      end
      if (cmd.clear_set) begin
        range_min <= TauMax;
        range_max <= '0;
      end
    end
  end

  // result register
  always_comb begin
    result_next = '0;
    if (cmd.emit_idx) begin
      result_next.pole_index  = out_idx;
      result_next.index_valid = 1'b1;
    end else if (cmd.emit_sum) begin
      result_next.last_result = 1'b1;
      result_next.too_many    = overflow;
      if (stat.degen) begin
        result_next.degenerate = 1'b1;
      end else begin
        result_next.dom_count             = nd_count;
        result_next.cluster_time_constant = hi;
        result_next.fastest_time_constant = range_min;
        result_next.tau_ratio             = (stat.ratio_sat || quo[63:TauW] != '0)
                                            ? TauMax : quo[TauW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end
endmodule

// File: rtl/dpts_ctrl.sv
// controller sequencing load, clustering, emission and summary
// depends on dpts_pkg
module dpts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  dpts_pkg::in_item_t in_item,
  input  dpts_pkg::stat_t    stat,
  input  logic               is_dom,
  output logic               busy,
  output dpts_pkg::cmd_t     cmd,
  output dpts_pkg::div_op_e  div_op,
  output logic [31:0]        mag,
  output logic [4:0]         addr,
  output logic [4:0]         out_idx,
  output logic [5:0]         nd_count,
  output logic               overflow,
  output logic               strobe
);
  import dpts_pkg::*;

  typedef enum logic [3:0] {
    Idle, RecipWait, Check, SeedSt, ScanRd, ScanAcc, Mean1, Mean2,
    EmitRd, EmitTest, RatioWait, Summary
  } state_t;

  state_t          state;
  logic [CntW-1:0] pole_count;
  logic [CntW-1:0] scan;
  logic [ItW-1:0]  iter;
  logic            last_seen;
  logic            mean_wait;
  logic [31:0]     raw;

  assign busy    = state != Idle;
  assign raw     = in_item.pole_real;
  assign out_idx = scan[IdxW-1:0];

  always_comb begin
    cmd    = '0;
    div_op = DivRecip;
    addr   = scan[IdxW-1:0];
    case (state)
      Idle: addr = pole_count[IdxW-1:0];
      RecipWait: begin
        addr = pole_count[IdxW-1:0];
        if (!mean_wait) begin
          if (mag != '0) cmd.div_start = 1'b1;
          else           cmd.store_inf = 1'b1;
        end
        cmd.store_tau = stat.div_done;
      end
      SeedSt: begin
        cmd.seed = 1'b1;
        cmd.clr_acc = 1'b1;
      end
      ScanAcc: cmd.acc = 1'b1;
      Mean1: begin
        div_op = DivMean;
        cmd.div_start = !mean_wait && !stat.n1_zero;
        cmd.load_c = stat.div_done;
      end
      Mean2: begin
        div_op = DivMean;
        cmd.mean_sel = 1'b1;
        cmd.div_start = !mean_wait && !stat.n2_zero;
        cmd.load_c = stat.div_done;
        // sums restart for the next round
        cmd.clr_acc = stat.div_done || (!mean_wait && stat.n2_zero);
      end
      EmitTest: cmd.emit_idx = is_dom;
      RatioWait: begin
        div_op = DivRatio;
        cmd.div_start = !mean_wait;
      end
      Summary: begin
        div_op = DivRatio;
        cmd.emit_sum = 1'b1;
        cmd.clear_set = 1'b1;
      end
      default: ;
    endcase
  end

  // magnitude of the incoming raw value, held for the reciprocal
  always_ff @(posedge clk) begin
    if (state == Idle && start) mag <= raw[31] ? 32'(-raw) : raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= Idle;
      pole_count <= '0;
      overflow   <= 1'b0;
      last_seen  <= 1'b0;
      scan       <= '0;
      iter       <= '0;
      mean_wait  <= 1'b0;
      nd_count   <= '0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        Idle: begin
          if (start) begin
            last_seen <= in_item.last_pole;
            if (pole_count == CntW'(MaxPoles)) begin
              overflow <= 1'b1;
              state <= in_item.last_pole ? Check : Idle;
            end else begin
              // magnitude is registered: decide zero in the next cycle
              state <= RecipWait;
              mean_wait <= 1'b0;
            end
          end
        end
        RecipWait: begin
          if (stat.div_done || (!mean_wait && mag == '0)) begin
            pole_count <= pole_count + 6'd1;
            mean_wait <= 1'b0;
            state <= last_seen ? Check : Idle;
          end else begin
            mean_wait <= 1'b1;
          end
        end
        Check: begin
          iter <= '0;
          nd_count <= '0;
          state <= stat.degen ? Summary : SeedSt;
        end
        SeedSt: begin
          scan <= '0;
          state <= ScanRd;
        end
        ScanRd: state <= ScanAcc;
        ScanAcc: begin
          if (scan + 6'd1 == pole_count) begin
            mean_wait <= 1'b0;
            state <= Mean1;
          end else begin
            scan <= scan + 6'd1;
            state <= ScanRd;
          end
        end
        Mean1: begin
          if (stat.div_done || (!mean_wait && stat.n1_zero)) begin
            mean_wait <= 1'b0;
            state <= Mean2;
          end else begin
            mean_wait <= 1'b1;
          end
        end
        Mean2: begin
          if (stat.div_done || (!mean_wait && stat.n2_zero)) begin
            mean_wait <= 1'b0;
            scan <= '0;
            if (iter == ItW'(Iterations - 1)) begin
              state <= EmitRd;
            end else begin
              iter <= iter + 4'd1;
              state <= ScanRd;
            end
          end else begin
            mean_wait <= 1'b1;
          end
        end
        EmitRd: state <= EmitTest;
        EmitTest: begin
          if (is_dom) begin
            strobe <= 1'b1;
            nd_count <= nd_count + 6'd1;
          end
          if (scan + 6'd1 == pole_count) begin
            mean_wait <= 1'b0;
            state <= RatioWait;
          end else begin
            scan <= scan + 6'd1;
            state <= EmitRd;
          end
        end
        RatioWait: begin
          mean_wait <= 1'b1;
          if (stat.div_done) state <= Summary;
        end
        Summary: begin
          strobe <= 1'b1;
          pole_count <= '0;
          overflow <= 1'b0;
          state <= Idle;
        end
        default: state <= Idle;
      endcase
    end
  end
endmodule
